// ===== hw/rtl/g2e_pkg.sv =====
// ----------------------------------------------------------------------------
// Geodetic to Earth-fixed conversion package
// Shared constants, types and the arctangent table generator.
// ----------------------------------------------------------------------------
package g2e_pkg;

  localparam int CORDIC_STAGES = 32;
  localparam int SQRT_STAGES   = 32;
  localparam int DIV_STAGES    = 50;
  localparam int MUL_LAT       = 3;
  localparam int CORDIC_LAT    = CORDIC_STAGES + 2;
  localparam int RADIUS_LAT    = SQRT_STAGES + DIV_STAGES + 3;
  localparam int TOTAL_LAT     = CORDIC_LAT + RADIUS_LAT + 2 * MUL_LAT + 1;

  localparam logic [63:0]        INV_PI_Q64      = 64'h517C_C1B7_2722_0A94;
  localparam logic signed [43:0] CORDIC_GAIN_Q40 = 44'sd667681663043;

  localparam logic [0:0]  REG_AXIS   = 1'b0;
  localparam logic [0:0]  REG_ECC    = 1'b1;
  localparam logic [32:0] AXIS_RESET = 33'd6378137000;
  localparam logic [31:0] ECC_RESET  = 32'd28752143;

  typedef logic signed [31:0] trig_t;
  typedef logic signed [51:0] wide_t;

  typedef struct packed {
    logic signed [30:0] h;
    trig_t              cl;
    trig_t              sl;
    trig_t              co;
    trig_t              so;
  } side_t;

  // Arctangent of 2^-i in units of pi/2^47, floored. Evaluated at elaboration.
  function automatic logic [63:0] atan_unit(input int unsigned i);
    logic [63:0]  acc;
    logic [63:0]  term;
    logic [63:0]  num;
    logic [63:0]  rem;
    logic [127:0] prod;
    int unsigned  k;
    int unsigned  m;
    int unsigned  b;
    acc = '0;
    if (i == 0) begin
      return 64'd1 << 45;
    end
    for (k = 0; (2 * k + 1) * i <= 62; k++) begin
      m    = 2 * k + 1;
      num  = 64'd1 << (62 - m * i);
      term = '0;
      rem  = '0;
      for (b = 0; b < 64; b++) begin
        rem  = {rem[62:0], num[63-b]};
        term = {term[62:0], 1'b0};
        if (rem >= 64'(m)) begin
          rem     = rem - 64'(m);
          term[0] = 1'b1;
        end
      end
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    prod = 128'(acc) * 128'(INV_PI_Q64);
    return 64'(prod[127:64] >> 15);
  endfunction

endpackage

// ===== hw/rtl/geodetic_to_ecef_wgs84.sv =====
// ----------------------------------------------------------------------------
// Geodetic to Earth-fixed (ECEF) converter
// Longitude, latitude and height in, X, Y and Z in millimetres out.
// ----------------------------------------------------------------------------
// The input channel takes one geodetic point per request: longitude and
// latitude as binary angles and height in millimetres. A request is taken at
// a clock edge with in_valid_i high and in_stall_o low. The output channel
// gives one X, Y, Z request per point, taken when out_valid_o is high and
// out_stall_i is low. Points leave in the order they came in.
// The pipeline has 126 register stages: 34 for the CORDIC rotations, 85 for
// the radius (two for sin^2 and 1 - e2 sin^2, 32 square-root steps, one for
// the numerator and 50 divide steps), six for the two rounds of products and
// one output register. One point can enter in every cycle when not held.
// The whole pipeline moves as one: it holds only while a result sits
// in the output register and the receiver stalls, and then in_stall_o is high.
// Reset empties the pipeline and loads the WGS84 axis and eccentricity into
// the configuration registers. The configuration port is always ready; the
// registers should only be written while no point is in flight.
// ----------------------------------------------------------------------------
module geodetic_to_ecef_wgs84 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] longitude_bam_i,
  input  logic signed [31:0] latitude_bam_i,
  input  logic signed [30:0] height_mm_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [33:0] x_mm_o,
  output logic signed [33:0] y_mm_o,
  output logic signed [33:0] z_mm_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [32:0]        cfg_data_i
);

  localparam int LC = g2e_pkg::CORDIC_LAT;
  localparam int LR = g2e_pkg::RADIUS_LAT;
  localparam int LM = g2e_pkg::MUL_LAT;
  localparam int LT = g2e_pkg::TOTAL_LAT;

  logic [32:0] axis_q;
  logic [31:0] ecc_q;

  logic          adv;
  logic [LT-1:0] vld_q;

  g2e_pkg::trig_t cl;
  g2e_pkg::trig_t sl;
  g2e_pkg::trig_t co;
  g2e_pkg::trig_t so;

  logic signed [30:0] h_q [LC];
  g2e_pkg::side_t     side_q [LR];
  g2e_pkg::side_t     side2_q [LM];

  logic [49:0]        n;
  g2e_pkg::wide_t     nh;
  g2e_pkg::wide_t     nw;
  logic signed [33:0] om_e2;
  g2e_pkg::wide_t     rc;
  g2e_pkg::wide_t     nb;
  g2e_pkg::wide_t     nbh;
  g2e_pkg::wide_t     xp;
  g2e_pkg::wide_t     yp;
  g2e_pkg::wide_t     zp;

  logic signed [33:0] x_q;
  logic signed [33:0] y_q;
  logic signed [33:0] z_q;

  function automatic logic signed [33:0] sat34(input g2e_pkg::wide_t v);
    logic signed [33:0] r;
    if (v > 52'sd8589934591) begin
      r = 34'sd8589934591;
    end else if (v < -52'sd8589934592) begin
      r = -34'sd8589934592;
    end else begin
      r = 34'(v);
    end
    return r;
  endfunction

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= g2e_pkg::AXIS_RESET;
      ecc_q  <= g2e_pkg::ECC_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        g2e_pkg::REG_AXIS: axis_q <= cfg_data_i;
        g2e_pkg::REG_ECC:  ecc_q  <= cfg_data_i[31:0];
        default:           axis_q <= axis_q;
      endcase
    end
  end

  // The pipeline moves whenever the output register is empty or being taken.
  assign adv        = !vld_q[LT-1] || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LT-2:0], in_valid_i};
    end
  end

  g2e_cordic u_cordic_lat (
    .clk_i (clk_i),
    .en_i  (adv),
    .ang_i (latitude_bam_i),
    .cos_o (cl),
    .sin_o (sl)
  );

  g2e_cordic u_cordic_lon (
    .clk_i (clk_i),
    .en_i  (adv),
    .ang_i (longitude_bam_i),
    .cos_o (co),
    .sin_o (so)
  );

  // Height and the trig values ride alongside the radius computation.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_q[0] <= height_mm_i;
      for (int k = 1; k < LC; k++) begin
        h_q[k] <= h_q[k-1];
      end
      side_q[0] <= '{h: h_q[LC-1], cl: cl, sl: sl, co: co, so: so};
      for (int k = 1; k < LR; k++) begin
        side_q[k] <= side_q[k-1];
      end
      side2_q[0] <= side_q[LR-1];
      for (int k = 1; k < LM; k++) begin
        side2_q[k] <= side2_q[k-1];
      end
    end
  end

  g2e_radius u_radius (
    .clk_i  (clk_i),
    .en_i   (adv),
    .sin_i  (sl),
    .ecc_i  (ecc_q),
    .axis_i (axis_q),
    .n_o    (n)
  );

  // First round of products: (N + h) cos(lat) and N (1 - e2).
  assign nw    = $signed({2'b00, n});
  assign nh    = nw + 52'(side_q[LR-1].h);
  assign om_e2 = $signed(34'(33'h1_0000_0000 - {1'b0, ecc_q}));

  g2e_mulsh u_mul_rc (
    .clk_i     (clk_i),
    .en_i      (adv),
    .shift32_i (1'b0),
    .a_i       (nh),
    .b_i       (34'(side_q[LR-1].cl)),
    .p_o       (rc)
  );

  g2e_mulsh u_mul_nb (
    .clk_i     (clk_i),
    .en_i      (adv),
    .shift32_i (1'b1),
    .a_i       (nw),
    .b_i       (om_e2),
    .p_o       (nb)
  );

  // Second round: the three coordinates.
  assign nbh = nb + 52'(side2_q[LM-1].h);

  g2e_mulsh u_mul_x (
    .clk_i     (clk_i),
    .en_i      (adv),
    .shift32_i (1'b0),
    .a_i       (rc),
    .b_i       (34'(side2_q[LM-1].co)),
    .p_o       (xp)
  );

  g2e_mulsh u_mul_y (
    .clk_i     (clk_i),
    .en_i      (adv),
    .shift32_i (1'b0),
    .a_i       (rc),
    .b_i       (34'(side2_q[LM-1].so)),
    .p_o       (yp)
  );

  g2e_mulsh u_mul_z (
    .clk_i     (clk_i),
    .en_i      (adv),
    .shift32_i (1'b0),
    .a_i       (nbh),
    .b_i       (34'(side2_q[LM-1].sl)),
    .p_o       (zp)
  );

  // Output register with clamping to the 34-bit result range.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q <= sat34(xp);
      y_q <= sat34(yp);
      z_q <= sat34(zp);
    end
  end

  assign out_valid_o = vld_q[LT-1];
  assign x_mm_o      = x_q;
  assign y_mm_o      = y_q;
  assign z_mm_o      = z_q;

  // The input holds only behind a full output register that is stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // While held, no valid bit in the pipeline moves.
  a_hold_valids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  // When moving, the output valid comes from the stage before it.
  a_valid_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |=> (out_valid_o == $past(vld_q[LT-2])))
    else $error("output valid out of step with the pipeline");

endmodule

// ===== hw/rtl/g2e_cordic.sv =====
// ----------------------------------------------------------------------------
// Pipelined CORDIC sine and cosine
// One rotation per register stage, quadrant fold in front, Q30 rounding behind.
// ----------------------------------------------------------------------------
module g2e_cordic (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [31:0]           ang_i,
  output g2e_pkg::trig_t        cos_o,
  output g2e_pkg::trig_t        sin_o
);

  localparam int NS = g2e_pkg::CORDIC_STAGES;

  logic signed [43:0] x_q [NS+1];
  logic signed [43:0] y_q [NS+1];
  logic signed [49:0] z_q [NS+1];
  logic               neg_q [NS+1];

  logic               quad_neg;
  logic [31:0]        ang_f;
  logic signed [49:0] z0;

  g2e_pkg::trig_t cos_q;
  g2e_pkg::trig_t sin_q;
  g2e_pkg::trig_t c_r;
  g2e_pkg::trig_t s_r;

  function automatic g2e_pkg::trig_t to_q30(input logic signed [43:0] v);
    logic signed [43:0] sum;
    logic signed [33:0] q;
    g2e_pkg::trig_t     r;
    sum = v + 44'sd512;
    q   = 34'(sum >>> 10);
    if (q > 34'sd1073741824) begin
      r = 32'sd1073741824;
    end else if (q < -34'sd1073741824) begin
      r = -32'sd1073741824;
    end else begin
      r = 32'(q);
    end
    return r;
  endfunction

  // Second and third quadrant angles are turned by half a circle.
  always_comb begin
    quad_neg = ang_i[31] ^ ang_i[30];
    ang_f    = {ang_i[31] ^ quad_neg, ang_i[30:0]};
    z0       = {{2{ang_f[31]}}, ang_f, 16'd0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= g2e_pkg::CORDIC_GAIN_Q40;
      y_q[0]   <= '0;
      z_q[0]   <= z0;
      neg_q[0] <= quad_neg;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam logic signed [49:0] ATAN = 50'(g2e_pkg::atan_unit(i));
    logic signed [43:0] dx;
    logic signed [43:0] dy;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][49]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - ATAN;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + ATAN;
        end
        neg_q[i+1] <= neg_q[i];
      end
    end
  end

  assign c_r = to_q30(x_q[NS]);
  assign s_r = to_q30(y_q[NS]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= neg_q[NS] ? -c_r : c_r;
      sin_q <= neg_q[NS] ? -s_r : s_r;
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

// ===== hw/rtl/g2e_radius.sv =====
// ----------------------------------------------------------------------------
// Prime-vertical radius
// Forms 1 - e2 sin^2, a bit-per-stage square root and a bit-per-stage divide.
// ----------------------------------------------------------------------------
module g2e_radius (
  input  logic           clk_i,
  input  logic           en_i,
  input  g2e_pkg::trig_t sin_i,
  input  logic [31:0]    ecc_i,
  input  logic [32:0]    axis_i,
  output logic [49:0]    n_o
);

  localparam int NQ = g2e_pkg::SQRT_STAGES;
  localparam int ND = g2e_pkg::DIV_STAGES;

  logic signed [63:0] sq;
  logic [60:0]        s2w;
  logic [32:0]        s2_d;
  logic [32:0]        s2_q;
  logic [64:0]        pe;
  logic [32:0]        dd;

  logic [63:0] v_q   [NQ+1];
  logic [63:0] res_q [NQ+1];

  logic [31:0] rt;
  logic [64:0] num;

  logic [49:0] num_q [ND+1];
  logic [31:0] r_q   [ND+1];
  logic [31:0] rem_q [ND+1];
  logic [49:0] quo_q [ND+1];

  always_comb begin
    sq  = sin_i * sin_i;
    s2w = sq[60:0] + 61'd134217728;
    if (s2w[60:28] > 33'h1_0000_0000) begin
      s2_d = 33'h1_0000_0000;
    end else begin
      s2_d = s2w[60:28];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign pe = 65'(ecc_i) * 65'(s2_q);
  assign dd = 33'h1_0000_0000 - pe[64:32];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[0]   <= {1'b0, dd, 30'd0};
      res_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < NQ; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;

    assign trial = res_q[k] + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_q[k] >= trial) begin
          v_q[k+1]   <= v_q[k] - trial;
          res_q[k+1] <= (res_q[k] >> 1) + BIT;
        end else begin
          v_q[k+1]   <= v_q[k];
          res_q[k+1] <= res_q[k] >> 1;
        end
      end
    end
  end

  // Numerator a*2^31 + r/2; its top bits sit below r, so 50 quotient bits do.
  assign rt  = res_q[NQ][31:0];
  assign num = {1'b0, axis_i, 31'd0} + 65'(rt >> 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= num[49:0];
      r_q[0]   <= rt;
      rem_q[0] <= 32'(num[64:50]);
      quo_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < ND; j++) begin : g_div
    logic [32:0] rem2;

    assign rem2 = {rem_q[j], num_q[j][ND-1-j]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[j+1] <= num_q[j];
        r_q[j+1]   <= r_q[j];
        if (rem2 >= {1'b0, r_q[j]}) begin
          rem_q[j+1] <= 32'(rem2 - {1'b0, r_q[j]});
          quo_q[j+1] <= {quo_q[j][ND-2:0], 1'b1};
        end else begin
          rem_q[j+1] <= rem2[31:0];
          quo_q[j+1] <= {quo_q[j][ND-2:0], 1'b0};
        end
      end
    end
  end

  assign n_o = quo_q[ND];

endmodule

// ===== hw/rtl/g2e_mulsh.sv =====
// ----------------------------------------------------------------------------
// Rounded scaling multiplier
// Sign-magnitude product split in two partial products, rounded half away.
// ----------------------------------------------------------------------------
module g2e_mulsh (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic               shift32_i,
  input  g2e_pkg::wide_t     a_i,
  input  logic signed [33:0] b_i,
  output g2e_pkg::wide_t     p_o
);

  logic        neg1_q;
  logic        neg2_q;
  logic [51:0] ma_q;
  logic [32:0] mb_q;
  logic [58:0] p0_q;
  logic [58:0] p1_q;
  logic [51:0] ma_d;
  logic [33:0] mb_d;
  logic [84:0] prod;
  logic [51:0] mag;
  g2e_pkg::wide_t p_q;

  assign ma_d = a_i[51] ? 52'(-a_i) : 52'(a_i);
  assign mb_d = b_i[33] ? 34'(-b_i) : 34'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= a_i[51] ^ b_i[33];
      ma_q   <= ma_d;
      mb_q   <= mb_d[32:0];
      neg2_q <= neg1_q;
      p0_q   <= 59'(ma_q[25:0]) * 59'(mb_q);
      p1_q   <= 59'(ma_q[51:26]) * 59'(mb_q);
    end
  end

  always_comb begin
    prod = {p1_q, 26'd0} + 85'(p0_q);
    if (shift32_i) begin
      prod = prod + (85'd1 << 31);
      mag  = prod[83:32];
    end else begin
      prod = prod + (85'd1 << 29);
      mag  = prod[81:30];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= neg2_q ? -$signed(mag) : $signed(mag);
    end
  end

  assign p_o = p_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Geodetic to Earth-fixed converter testbench
// Drives geodetic points through the converter under random idling and
// stalls, predicts each X, Y, Z request with a bit-exact fixed-point model
// and compares every result in order, across several ellipsoid settings.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic signed [31:0] lon;
    logic signed [31:0] lat;
    logic signed [30:0] h;
  } point_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } ecef_t;

  typedef struct packed {
    logic [0:0]  idx;
    logic [32:0] data;
  } reg_write_t;

  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE     = g2e_pkg::TOTAL_LAT + 10;
  localparam int HOLD_OFF   = 400;

  // Clock, reset and every block input start at known values.
  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic signed [31:0] longitude_bam_i = '0;
  logic signed [31:0] latitude_bam_i  = '0;
  logic signed [30:0] height_mm_i     = '0;
  logic               out_stall_i     = 1'b1;
  logic               cfg_valid_i     = 1'b0;
  logic [0:0]         cfg_index_i     = g2e_pkg::REG_AXIS;
  logic [32:0]        cfg_data_i      = '0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic signed [33:0] x_mm_o;
  logic signed [33:0] y_mm_o;
  logic signed [33:0] z_mm_o;
  logic               cfg_ready_o;

  geodetic_to_ecef_wgs84 dut (.*);

  always #5 clk_i = ~clk_i;

  // Testbench copy of the ellipsoid registers, updated when a write lands.
  logic [32:0] axis_mm;
  logic [31:0] ecc_q32;
  logic [63:0] atan_tab [g2e_pkg::CORDIC_STAGES];

  point_t     pending_points[$];
  ecef_t      expected_ecef[$];
  reg_write_t pending_writes[$];

  int  errors    = 0;
  bit  no_idle   = 1'b0;
  bit  hold_req  = 1'b0;

  // --------------------------------------------------------------------------
  // Fixed-point model of the converter.
  // --------------------------------------------------------------------------

  // Arctangent of 2^-i in units of pi/2^47, from an odd power series in Q62.
  function automatic logic [63:0] arctan_step(int unsigned i);
    logic [63:0]  acc;
    logic [127:0] prod;
    int unsigned  k;
    acc = '0;
    if (i == 0) return 64'd1 << 45;
    for (k = 0; (2 * k + 1) * i <= 62; k++) begin
      if (k % 2 == 1) acc = acc - (64'd1 << (62 - (2 * k + 1) * i)) / 64'(2 * k + 1);
      else acc = acc + (64'd1 << (62 - (2 * k + 1) * i)) / 64'(2 * k + 1);
    end
    prod = 128'(acc) * 128'(g2e_pkg::INV_PI_Q64);
    return 64'(prod[127:64] >> 15);
  endfunction

  // Product a*b/2^s rounded half away from zero, saturated to 63 bits.
  function automatic logic signed [63:0] scaled_mul(logic signed [63:0] a,
                                                    logic signed [63:0] b,
                                                    int unsigned s);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] prod;
    logic [63:0]  mag;
    ua   = a[63] ? -a : a;
    ub   = b[63] ? -b : b;
    prod = 128'(ua) * 128'(ub) + (128'd1 << (s - 1));
    prod = prod >> s;
    mag  = (prod >= (128'd1 << 63)) ? 64'h7FFF_FFFF_FFFF_FFFF : prod[63:0];
    return (a[63] != b[63]) ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [63:0] round_q30(logic signed [63:0] v);
    logic signed [63:0] q;
    q = (v + 64'sd512) >>> 10;
    if (q > (64'sd1 <<< 30)) q = 64'sd1 <<< 30;
    if (q < -(64'sd1 <<< 30)) q = -(64'sd1 <<< 30);
    return q;
  endfunction

  // Rotation-mode CORDIC on a binary angle, with the half-turn fold.
  task automatic bam_sincos(input logic [31:0] ang, output logic signed [63:0] c,
                            output logic signed [63:0] s);
    logic               flip;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang + 32'h8000_0000;
    x = 64'(g2e_pkg::CORDIC_GAIN_Q40);
    y = '0;
    z = {{32{ang[31]}}, ang} <<< 16;
    for (int i = 0; i < g2e_pkg::CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (!z[63]) begin
        x = x - dx; y = y + dy; z = z - $signed(atan_tab[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + $signed(atan_tab[i]);
      end
    end
    x = round_q30(x);
    y = round_q30(y);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [33:0] clamp34(logic signed [63:0] v);
    if (v > 64'sd8589934591) return 34'sh1_FFFF_FFFF;
    if (v < -64'sd8589934592) return 34'sh2_0000_0000;
    return v[33:0];
  endfunction

  task automatic predict_ecef(input point_t pt, output ecef_t res);
    logic signed [63:0] cl, sl, co, so, h, n, rc, nb;
    logic [63:0]        s2, p, d, r;
    logic [127:0]       ep;
    bam_sincos(pt.lat, cl, sl);
    bam_sincos(pt.lon, co, so);
    h  = 64'(pt.h);
    s2 = (64'(sl * sl) + (64'd1 << 27)) >> 28;
    if (s2 > (64'd1 << 32)) s2 = 64'd1 << 32;
    ep = 128'(ecc_q32) * 128'(s2);
    p  = ep[95:32];
    d  = (64'd1 << 32) - p;
    r  = floor_sqrt(d << 30);
    n  = ((64'(axis_mm) << 31) + (r >> 1)) / r;
    rc = scaled_mul(n + h, cl, 30);
    nb = scaled_mul(n, $signed((64'd1 << 32) - 64'(ecc_q32)), 32);
    res.x = clamp34(scaled_mul(rc, co, 30));
    res.y = clamp34(scaled_mul(rc, so, 30));
    res.z = clamp34(scaled_mul(nb + h, sl, 30));
  endtask

  // --------------------------------------------------------------------------
  // Input driver: presents queued points and predicts each accepted request.
  // --------------------------------------------------------------------------
  int     in_gap;
  bit     in_busy;
  point_t in_point;
  ecef_t  in_pred;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     = 0;
    end else begin
      in_busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        in_point = '{longitude_bam_i, latitude_bam_i, height_mm_i};
        predict_ecef(in_point, in_pred);
        expected_ecef.push_back(in_pred);
        in_busy = 1'b0;
        in_gap  = no_idle ? 0 : $urandom_range(0, 17);
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_points.size() > 0) begin
          in_point = pending_points.pop_front();
          longitude_bam_i <= in_point.lon;
          latitude_bam_i  <= in_point.lat;
          height_mm_i     <= in_point.h;
          in_busy = 1'b1;
        end
      end
      in_valid_i <= in_busy;
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: random stalls, one long hold-off on request, and the
  // in-order comparison against the predicted coordinates.
  // --------------------------------------------------------------------------
  int    out_wait;
  ecef_t out_want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
      out_wait    = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_ecef.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                   x_mm_o, y_mm_o, z_mm_o);
          errors++;
        end else begin
          out_want = expected_ecef.pop_front();
          if (out_want.x !== x_mm_o || out_want.y !== y_mm_o || out_want.z !== z_mm_o) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d actual x=%0d y=%0d z=%0d",
                     $time, out_want.x, out_want.y, out_want.z, x_mm_o, y_mm_o, z_mm_o);
            errors++;
          end
        end
        out_wait = no_idle ? 0 : $urandom_range(0, 17);
      end
      // The long hold-off lets the pipeline fill and push back on the input.
      if (hold_req) begin
        hold_req = 1'b0;
        out_wait = HOLD_OFF;
      end
      if (out_wait > 0) begin
        out_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register writer: applies queued writes and mirrors them into the model.
  // --------------------------------------------------------------------------
  reg_write_t wr_next;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
      axis_mm     = g2e_pkg::AXIS_RESET;
      ecc_q32     = g2e_pkg::ECC_RESET;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == g2e_pkg::REG_AXIS) axis_mm = cfg_data_i;
        else ecc_q32 = cfg_data_i[31:0];
      end
      if ((!cfg_valid_i || cfg_ready_o) && pending_writes.size() > 0) begin
        wr_next = pending_writes.pop_front();
        cfg_index_i <= wr_next.idx;
        cfg_data_i  <= wr_next.data;
        cfg_valid_i <= 1'b1;
      end else if (cfg_ready_o) begin
        cfg_valid_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which no request of any kind moves.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic point_t random_point();
    point_t pt;
    int     pick;
    pick   = $urandom_range(0, 9);
    pt.lon = $urandom();
    // Mostly legal latitudes and heights, with some out-of-range noise.
    pt.lat = (pick == 0) ? $signed($urandom())
                         : $signed($urandom_range(32'h8000_0000, 0)) - 32'sh4000_0000;
    pt.h   = (pick == 1) ? 31'($urandom())
                         : 31'($signed($urandom_range(2000000000, 0)) - 1000000000);
    return pt;
  endfunction

  task automatic add_point(logic signed [31:0] lon, logic signed [31:0] lat,
                           logic signed [30:0] h);
    pending_points.push_back('{lon, lat, h});
  endtask

  // Waits until every point has come back and the pipeline has drained.
  // Sampling on the falling edge sees the state after each rising edge settles.
  task automatic drain();
    do begin
      @(negedge clk_i);
    end while (pending_points.size() != 0 || in_valid_i || expected_ecef.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_ellipsoid(logic [32:0] axis, logic [31:0] ecc);
    pending_writes.push_back('{g2e_pkg::REG_AXIS, axis});
    pending_writes.push_back('{g2e_pkg::REG_ECC, 33'(ecc)});
    do begin
      @(negedge clk_i);
    end while (pending_writes.size() != 0 || cfg_valid_i);
    @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < g2e_pkg::CORDIC_STAGES; i++) atan_tab[i] = arctan_step(i);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points under the reset ellipsoid: axis crossings, poles,
    // latitudes past a pole, and the height extremes.
    add_point(32'sd0, 32'sd0, 31'sd0);
    add_point(32'sh4000_0000, 32'sd0, 31'sd1000000000);
    add_point(-32'sh4000_0000, 32'sd0, -31'sd1000000000);
    add_point(32'sh8000_0000, 32'sd0, 31'sd0);
    add_point(32'sh7FFF_FFFF, 32'sd0, 31'sd0);
    add_point(32'sd0, 32'sh4000_0000, 31'sd0);
    add_point(32'sd0, -32'sh4000_0000, 31'sd0);
    add_point(32'sd12345, 32'sh4000_0000, 31'sd1000000000);
    add_point(32'sd0, 32'sh4000_1000, 31'sd500);
    add_point(32'sh2000_0000, 32'sh8000_0000, 31'sd0);
    add_point(32'sh2000_0000, 32'sh7FFF_FFFF, 31'sh3FFF_FFFF);
    add_point(-32'sh6000_0000, 32'sh2000_0000, 31'sh4000_0000);
    add_point(32'sh1234_5678, -32'sh2AAA_AAAA, -31'sd1);
    add_point(32'sh0000_0001, 32'sh0000_0001, 31'sd1);
    add_point(32'shFFFF_FFFF, 32'shFFFF_FFFF, -31'sd1000000000);
    drain();

    // Each setting runs a batch of random points; idling and the hold-off
    // vary between batches.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_ellipsoid(33'd6378137000, 32'd28752143);
        1: set_ellipsoid(33'd6000000000, 32'd0);
        2: set_ellipsoid(33'd7000000000, 32'hFFFF_FFFF);
        3: set_ellipsoid(33'd0, $urandom());
        4: set_ellipsoid(33'h1_FFFF_FFFF, $urandom());
        5: set_ellipsoid({1'($urandom()), 32'($urandom())}, $urandom());
        default: set_ellipsoid(33'($urandom_range(1000000000, 0)) + 33'd6000000000,
                               $urandom_range(100000000, 0));
      endcase
      no_idle  = (ph % 3 == 1);
      hold_req = (ph == 2 || ph == 5);
      repeat (250) pending_points.push_back(random_point());
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
